### rtl/stl_pkg.sv
// Shared types and constants for the sorted software timer list.
package stl_pkg;

  localparam int unsigned NUM_SLOTS = 64;
  localparam int unsigned ID_W      = 6;
  localparam int unsigned CELLS     = NUM_SLOTS - 1;
  localparam int unsigned CNT_W     = 6;

  // One timer as it sits in a cell
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
    logic [31:0]     dl;
    logic [31:0]     rl;
  } entry_t;

  // List cell commands
  localparam logic [1:0] LC_HOLD  = 2'd0;
  localparam logic [1:0] LC_INS   = 2'd1;
  localparam logic [1:0] LC_SHIFT = 2'd2;

  // Pending queue cell commands
  localparam logic [1:0] PC_HOLD  = 2'd0;
  localparam logic [1:0] PC_PUSH  = 2'd1;
  localparam logic [1:0] PC_SHIFT = 2'd2;

  // Result kinds
  localparam logic KIND_SET    = 1'b0;
  localparam logic KIND_EXPIRE = 1'b1;

endpackage

### rtl/stl_cell.sv
// One cell of the sorted timer chain: holds a timer, inserts or shifts left.
module stl_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        cmd_i,
  input  stl_pkg::entry_t   new_i,
  input  stl_pkg::entry_t   left_i,
  input  logic              left_ins_i,
  input  stl_pkg::entry_t   right_i,
  output stl_pkg::entry_t   ent_o,
  output logic              ins_o
);

  stl_pkg::entry_t ent_q, ent_d;

  // Insert point: empty cell or new deadline not above ours
  assign ins_o = !ent_q.valid || (new_i.dl <= ent_q.dl);

  // Pick next contents
  always_comb begin
    ent_d = ent_q;
    case (cmd_i)
      stl_pkg::LC_INS: begin
        if (left_ins_i) begin
          ent_d = left_i;
        end else if (ins_o) begin
          ent_d = new_i;
        end
      end
      stl_pkg::LC_SHIFT: ent_d = right_i;
      default: ent_d = ent_q;
    endcase
  end

  // Hold the entry, empty under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;

endmodule

### rtl/stl_pend.sv
// One cell of the queue of fired periodic timers awaiting re-insertion.
module stl_pend (
  input  logic              clk_i,
  input  logic [1:0]        cmd_i,
  input  logic              sel_i,
  input  stl_pkg::entry_t   in_i,
  input  stl_pkg::entry_t   right_i,
  output stl_pkg::entry_t   ent_o
);

  stl_pkg::entry_t ent_q;

  // Write on push when selected, take right neighbor on shift
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      stl_pkg::PC_PUSH: begin
        if (sel_i) begin
          ent_q <= in_i;
        end
      end
      stl_pkg::PC_SHIFT: ent_q <= right_i;
      default: ent_q <= ent_q;
    endcase
  end

  assign ent_o = ent_q;

endmodule

### rtl/sorted_software_timer_list_core.sv
// Top level of the sorted software timer list.
// Usage: raise start_i with opcode_i, delay_ticks_i and reload_ticks_i while
// busy_o is low; the word is taken at that edge. opcode 1 sets a timer,
// opcode 0 passes one tick. Results come out one per cycle on kind_o,
// timer_id_o and last_o, marked by strobe_o for exactly one cycle; the
// receiver cannot stall, so each result is taken as it appears.
// A set answers with one result (id 0 means refused). A tick with nothing
// due emits no result; when a run of timers fires, it emits one result per
// timer and then re-links the periodic ones, one per cycle through the
// pending queue. Sorting is done by a chain of 63 cells that all compare
// against the new deadline at once and shift right past the insert point,
// so an insert needs no search along the chain.
// Reset empties the chain, frees every slot and clears the tick count.
module sorted_software_timer_list_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        opcode_i,
  input  logic [31:0] delay_ticks_i,
  input  logic [31:0] reload_ticks_i,
  output logic        strobe_o,
  output logic        kind_o,
  output logic [5:0]  timer_id_o,
  output logic        last_o
);

  localparam int unsigned CELLS = stl_pkg::CELLS;
  localparam int unsigned ID_W  = stl_pkg::ID_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SET   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_POP   = 3'd3;
  localparam logic [2:0] S_REINS = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [31:0] tick_q, tick_d;
  logic [31:0] dly_q, rld_q;
  logic [CELLS:1] used_q, used_d;
  logic [stl_pkg::CNT_W-1:0] pcnt_q, pcnt_d;
  logic        stb_q, stb_d, kind_q, kind_d, last_q, last_d;
  logic [ID_W-1:0] id_q, id_d;

  logic [1:0]      lcmd, pcmd;
  stl_pkg::entry_t new_ent, push_ent;
  stl_pkg::entry_t ent_w [CELLS];
  logic            ins_w [CELLS];
  stl_pkg::entry_t pend_w [CELLS];

  logic            free_any;
  logic [ID_W-1:0] free_id;
  logic [32:0]     sum;
  logic            fire_last;

  // Lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_id  = '0;
    for (int i = CELLS; i >= 1; i--) begin
      if (!used_q[i]) begin
        free_any = 1'b1;
        free_id  = ID_W'(i);
      end
    end
  end

  assign sum       = {1'b0, dly_q} + {1'b0, tick_q};
  assign fire_last = !(ent_w[1].valid && (ent_w[1].dl == ent_w[0].dl));

  // Sequencer
  always_comb begin
    state_d  = state_q;
    tick_d   = tick_q;
    used_d   = used_q;
    pcnt_d   = pcnt_q;
    stb_d    = 1'b0;
    kind_d   = kind_q;
    id_d     = id_q;
    last_d   = last_q;
    lcmd     = stl_pkg::LC_HOLD;
    pcmd     = stl_pkg::PC_HOLD;
    new_ent  = '0;
    push_ent = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (opcode_i) begin
            state_d = S_SET;
          end else begin
            tick_d  = tick_q + 32'd1;
            state_d = S_CHECK;
          end
        end
      end
      S_SET: begin
        stb_d  = 1'b1;
        kind_d = stl_pkg::KIND_SET;
        last_d = 1'b1;
        id_d   = '0;
        if (!sum[32] && free_any) begin
          id_d            = free_id;
          used_d[free_id] = 1'b1;
          new_ent         = '{valid: 1'b1, id: free_id, dl: sum[31:0], rl: rld_q};
          lcmd            = stl_pkg::LC_INS;
        end
        state_d = S_IDLE;
      end
      S_CHECK: begin
        if (ent_w[0].valid && (tick_q >= ent_w[0].dl)) begin
          state_d = S_POP;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_POP: begin
        stb_d  = 1'b1;
        kind_d = stl_pkg::KIND_EXPIRE;
        id_d   = ent_w[0].id;
        last_d = fire_last;
        lcmd   = stl_pkg::LC_SHIFT;
        if (ent_w[0].rl != 32'd0) begin
          push_ent = '{valid: 1'b1, id: ent_w[0].id,
                       dl: ent_w[0].dl + ent_w[0].rl, rl: ent_w[0].rl};
          pcmd     = stl_pkg::PC_PUSH;
          pcnt_d   = pcnt_q + 1'b1;
        end else begin
          used_d[ent_w[0].id] = 1'b0;
        end
        if (fire_last) begin
          state_d = (pcnt_d != '0) ? S_REINS : S_IDLE;
        end
      end
      S_REINS: begin
        new_ent = pend_w[0];
        lcmd    = stl_pkg::LC_INS;
        pcmd    = stl_pkg::PC_SHIFT;
        pcnt_d  = pcnt_q - 1'b1;
        if (pcnt_q == stl_pkg::CNT_W'(1)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tick_q  <= '0;
      used_q  <= '0;
      pcnt_q  <= '0;
      stb_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      tick_q  <= tick_d;
      used_q  <= used_d;
      pcnt_q  <= pcnt_d;
      stb_q   <= stb_d;
    end
  end

  // Latch the set word and the result word
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      dly_q <= delay_ticks_i;
      rld_q <= reload_ticks_i;
    end
    kind_q <= kind_d;
    id_q   <= id_d;
    last_q <= last_d;
  end

  // Chain of list cells and pending cells
  for (genvar g = 0; g < CELLS; g++) begin : g_cells
    stl_pkg::entry_t left_e, right_e, pright_e;
    logic            left_ins;
    if (g == 0) begin : g_first
      assign left_e   = '0;
      assign left_ins = 1'b0;
    end else begin : g_mid
      assign left_e   = ent_w[g-1];
      assign left_ins = ins_w[g-1];
    end
    if (g == CELLS - 1) begin : g_tail
      assign right_e  = '0;
      assign pright_e = '0;
    end else begin : g_body
      assign right_e  = ent_w[g+1];
      assign pright_e = pend_w[g+1];
    end

    stl_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (lcmd),
      .new_i     (new_ent),
      .left_i    (left_e),
      .left_ins_i(left_ins),
      .right_i   (right_e),
      .ent_o     (ent_w[g]),
      .ins_o     (ins_w[g])
    );

    stl_pend u_pend (
      .clk_i  (clk_i),
      .cmd_i  (pcmd),
      .sel_i  (pcnt_q == stl_pkg::CNT_W'(g)),
      .in_i   (push_ent),
      .right_i(pright_e),
      .ent_o  (pend_w[g])
    );
  end

  assign busy_o     = (state_q != S_IDLE);
  assign strobe_o   = stb_q;
  assign kind_o     = kind_q;
  assign timer_id_o = id_q;
  assign last_o     = last_q;

endmodule
